// ----- sv/fbfl_pkg.sv -----
// Shared constants, codes and types of the fixed-block free-list allocator.
package fbfl_pkg;

	localparam int unsigned LINK_DEPTH = 255;

	// request codes
	localparam logic [1:0] REQ_INIT    = 2'd0;
	localparam logic [1:0] REQ_ACQUIRE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_NO_FREE    = 3'd1;
	localparam logic [2:0] STAT_RANGE      = 3'd2;
	localparam logic [2:0] STAT_MISALIGNED = 3'd3;
	localparam logic [2:0] STAT_NONE_ALLOC = 3'd4;

	// ownership codes
	localparam logic [1:0] OWN_INSIDE = 2'd0;
	localparam logic [1:0] OWN_BELOW  = 2'd1;
	localparam logic [1:0] OWN_BEYOND = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd1;
	localparam logic [1:0] CFG_CHUNK_SIZE   = 2'd2;

	// divider status back to the sequencer
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] quot;      // low quotient bits
		logic       quot_ovf;  // quotient above 255
		logic       rem_zero;
	} div_res_t;

endpackage

// ----- sv/fbfl_div.sv -----
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module fbfl_div import fbfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output div_res_t    res
);

	logic [31:0] dvd_q;
	logic [15:0] dsr_q;
	logic [15:0] rem_q;
	logic [7:0]  quot_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[31]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[30:0], 1'b0};
			// partial remainder always stays below the divisor
			rem_q  <= fits ? diff[15:0] : trial[15:0];
			quot_q <= {quot_q[6:0], fits};
			ovf_q  <= ovf_q | quot_q[7];
		end
	end

	assign res.busy     = busy_q;
	assign res.done     = done_q;
	assign res.quot     = quot_q;
	assign res.quot_ovf = ovf_q;
	assign res.rem_zero = (rem_q == 16'd0);

endmodule

// ----- sv/fixed_block_free_list_allocator_top.sv -----
// Top level of the fixed-block free-list allocator: sequencer, link memory, output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  cfg     | in        | cfg_we (no wait)   | cfg_index, cfg_data
//  request | in        | in_valid/in_ready  | req_type, address
//  result  | out       | out_valid/out_ready| block_address, block_index, status, owner,
//          |           |                    | allocated_count, all_free
//
// The 32-step shared divider serves release and init; init then writes one link per cycle
// through the single write port of the link memory. One request is in work at a time;
// in_ready is high whenever the sequencer is idle, also while a finished result still
// waits in the output register.
// Reset clears the sequencer, free list pointers, base, chunk size and out_valid and sets the
// block size to one; the link memory is not cleared and only holds meaning after an init.
module fixed_block_free_list_allocator_top import fbfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] address,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] block_address,
	output logic [7:0]  block_index,
	output logic [2:0]  status,
	output logic [1:0]  owner,
	output logic [7:0]  allocated_count,
	output logic        all_free
);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;  // range compare for release / query
	localparam logic [2:0] S_DIV   = 3'd2;  // wait on shared divider
	localparam logic [2:0] S_MUL   = 3'd3;  // chunk end from block count
	localparam logic [2:0] S_LINK  = 3'd4;  // init sweep of link memory
	localparam logic [2:0] S_ARD   = 3'd5;  // link read for acquire
	localparam logic [2:0] S_AUPD  = 3'd6;  // pop head, form address
	localparam logic [2:0] S_OUT   = 3'd7;  // hand result to output register

	localparam logic [7:0] LAST_IDX = 8'(LINK_DEPTH);

	logic [2:0]  state_q;

	// configuration registers
	logic [31:0] base_q;
	logic [15:0] bsize_q;
	logic [31:0] csize_q;

	// allocator state
	logic [7:0]  head_q;
	logic [7:0]  fc_q;     // free count
	logic [7:0]  bc_q;     // block count
	logic [31:0] end_q;
	logic [7:0]  cnt_q;    // link sweep index

	// request and result holding
	logic [1:0]  req_q;
	logic [31:0] addr_q;
	logic [31:0] res_addr_q;
	logic [7:0]  res_idx_q;
	logic [2:0]  res_status_q;
	logic [1:0]  res_owner_q;

	// output register
	logic        out_valid_q;
	logic [31:0] block_address_q;
	logic [7:0]  block_index_q;
	logic [2:0]  status_q;
	logic [1:0]  owner_q;
	logic [7:0]  alloc_q;
	logic        all_free_q;

	// link memory
	logic [7:0]  link_mem [0:LINK_DEPTH-1];
	logic [7:0]  link_rd_q;
	logic        lnk_we;
	logic [7:0]  lnk_wa;
	logic [7:0]  lnk_wd;

	logic        in_xfer;
	logic        out_free;
	logic [15:0] eff_bs;
	logic [7:0]  mul_a;
	logic [23:0] prod;
	logic [32:0] end_sum;
	logic [1:0]  own_c;
	logic        div_start;
	logic [31:0] div_dvd;
	div_res_t    div_res;
	logic        rel_ok;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// a zero block size behaves as one byte
	assign eff_bs = (bsize_q == 16'd0) ? 16'd1 : bsize_q;

	// one 8x16 multiplier: block count at init, head index at acquire
	assign mul_a   = (state_q == S_MUL) ? bc_q : head_q;
	assign prod    = mul_a * eff_bs;
	assign end_sum = {1'b0, base_q} + {9'd0, prod};

	always_comb begin
		if (addr_q < base_q) begin
			own_c = OWN_BELOW;
		end else if (addr_q >= end_q) begin
			own_c = OWN_BEYOND;
		end else begin
			own_c = OWN_INSIDE;
		end
	end

	// divider: chunk size at init, offset into chunk at release
	assign div_start = (in_xfer && req_type == REQ_INIT) ||
		(state_q == S_CLASS && req_q == REQ_RELEASE && own_c == OWN_INSIDE);
	assign div_dvd   = (state_q == S_IDLE) ? csize_q : (addr_q - base_q);

	fbfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (eff_bs),
		.res      (div_res)
	);

	// release passes every check: push the index
	assign rel_ok = div_res.rem_zero && !div_res.quot_ovf && (div_res.quot < bc_q) &&
		(fc_q < bc_q);

	always_comb begin
		lnk_we = 1'b0;
		lnk_wa = cnt_q;
		lnk_wd = cnt_q + 8'd1;
		if (state_q == S_LINK) begin
			lnk_we = 1'b1;
		end else if (state_q == S_DIV && div_res.done && req_q == REQ_RELEASE && rel_ok) begin
			lnk_we = 1'b1;
			lnk_wa = div_res.quot;
			lnk_wd = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			link_mem[lnk_wa] <= lnk_wd;
		end
		if (head_q != LAST_IDX) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	// sequencer and state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			bsize_q     <= 16'd1;
			csize_q     <= '0;
			head_q      <= '0;
			fc_q        <= '0;
			bc_q        <= '0;
			end_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE_ADDRESS: base_q  <= cfg_data;
					CFG_BLOCK_SIZE:   bsize_q <= cfg_data[15:0];
					CFG_CHUNK_SIZE:   csize_q <= cfg_data;
					default: ;
				endcase
			end

			// hand-off loads the output register, a transfer out empties it
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (req_type)
							REQ_INIT:    state_q <= S_DIV;
							REQ_ACQUIRE: state_q <= (fc_q == 8'd0) ? S_OUT : S_ARD;
							REQ_RELEASE: state_q <= S_CLASS;
							REQ_QUERY:   state_q <= S_CLASS;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_CLASS: begin
					state_q <= div_start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_res.done) begin
						if (req_q == REQ_INIT) begin
							// block count saturates at the link store depth
							bc_q    <= div_res.quot_ovf ? LAST_IDX : div_res.quot;
							fc_q    <= div_res.quot_ovf ? LAST_IDX : div_res.quot;
							head_q  <= '0;
							state_q <= S_MUL;
						end else begin
							if (rel_ok) begin
								head_q <= div_res.quot;
								fc_q   <= fc_q + 8'd1;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: begin
					end_q   <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
					cnt_q   <= '0;
					state_q <= (bc_q == 8'd0) ? S_OUT : S_LINK;
				end
				S_LINK: begin
					if (cnt_q == bc_q - 8'd1) begin
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_ARD: begin
					state_q <= S_AUPD;
				end
				S_AUPD: begin
					// the end-of-list index has no link entry
					head_q  <= (head_q == LAST_IDX) ? 8'd0 : link_rd_q;
					fc_q    <= fc_q - 8'd1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request latch, result build-up and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q        <= req_type;
			addr_q       <= address;
			res_addr_q   <= '0;
			res_idx_q    <= '0;
			res_owner_q  <= OWN_INSIDE;
			res_status_q <= (req_type == REQ_ACQUIRE && fc_q == 8'd0) ? STAT_NO_FREE : STAT_OK;
		end
		if (state_q == S_CLASS) begin
			res_owner_q <= own_c;
			if (req_q == REQ_RELEASE && own_c != OWN_INSIDE) begin
				res_status_q <= STAT_RANGE;
			end
		end
		if (state_q == S_DIV && div_res.done && req_q == REQ_RELEASE) begin
			priority if (!div_res.rem_zero) begin
				res_status_q <= STAT_MISALIGNED;
			end else if (div_res.quot_ovf || div_res.quot >= bc_q) begin
				res_status_q <= STAT_RANGE;
			end else if (fc_q >= bc_q) begin
				res_status_q <= STAT_NONE_ALLOC;
			end else begin
				res_idx_q <= div_res.quot;
			end
		end
		if (state_q == S_AUPD) begin
			res_addr_q <= base_q + {8'd0, prod};
			res_idx_q  <= head_q;
		end
		if (state_q == S_OUT && out_free) begin
			block_address_q <= res_addr_q;
			block_index_q   <= res_idx_q;
			status_q        <= res_status_q;
			owner_q         <= res_owner_q;
			alloc_q         <= (fc_q >= bc_q) ? 8'd0 : (bc_q - fc_q);
			all_free_q      <= (fc_q >= bc_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign block_address   = block_address_q;
	assign block_index     = block_index_q;
	assign status          = status_q;
	assign owner           = owner_q;
	assign allocated_count = alloc_q;
	assign all_free        = all_free_q;

	// free count can never pass the block count
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= bc_q)
		else $error("free count above block count");

	// divider completes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside wait state");

	// no division left running once idle
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_res.busy)
		else $error("divider busy while idle");

	// a new result appears only from the hand-off state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result valid without hand-off");

endmodule
